>>> rtl/core/url_scheme_host_port_splitter_defines.svh
// assertion macros used by the url splitter port checker
`ifndef URL_SCHEME_HOST_PORT_SPLITTER_DEFINES_SVH
`define URL_SCHEME_HOST_PORT_SPLITTER_DEFINES_SVH

// same-cycle implication, off during reset
`define USPH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define USPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define USPH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/usph_pkg.sv
// types, constants and codes of the url scheme/host/port splitter
package usph_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int POS_W      = $clog2(MAX_LEN);
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 10;
   localparam int PORT_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOSLASH = 2'd1,
      ST_BADPORT = 2'd2,
      ST_NOPORT  = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_SCHEME = 6'b000001,
      PH_SLASH1 = 6'b000010,
      PH_SLASH2 = 6'b000100,
      PH_HOST   = 6'b001000,
      PH_PORT   = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } item_type;

   typedef struct packed {
      status_type         status;
      logic [IDX_W-1:0]   scheme_len;
      logic [IDX_W-1:0]   host_start;
      logic [IDX_W-1:0]   host_end;
      logic [PORT_W-1:0]  port_number;
   } result_type;

   typedef struct packed {
      logic take;
      logic emit;
   } parse_ctrl_type;

   function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] p);
      sat_next = (p == POS_MAX) ? p : p + POS_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [POS_W-1:0] p);
      to_idx = IDX_W'(p);
   endfunction

endpackage

>>> rtl/core/url_scheme_host_port_splitter.sv
// top level of the url scheme/host/port splitter
//
// req channel: one url character per word, req_tlast on the final character.
// rsp channel: exactly one word per url, carrying the status code in
// rsp_tuser and the scheme length, host start, host end and port number in
// rsp_tdata. The port number is zero unless the status is ok.
// A word is taken on every cycle when the output side keeps up: one
// character per cycle sustained. The result for the character that decides
// the parse passes through the input register, then the result register
// fed by the single-pass parse logic, before it is valid on rsp.
// Characters after the deciding one are consumed without a result until
// req_tlast; the next word then starts a new url.
// Reset clears the parse state and the valid flags of both registers; the
// block is ready for a new url in the cycle after reset is released.
// When the receiver stalls, the pending result holds in the result register
// and characters that produce no result keep flowing; a character that
// would produce a result waits in the input register until the result
// register frees up.
module url_scheme_host_port_splitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [usph_pkg::REQ_DATA_W-1:0] req_tdata,  // byte_in
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // scheme_len, host_start, host_end, port_number, zero fill
   output logic [usph_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [usph_pkg::STATUS_W-1:0]   rsp_tuser   // status
);

   logic                     item_vld;
   usph_pkg::item_type       item;
   usph_pkg::parse_ctrl_type ctrl;
   usph_pkg::result_type     result;
   logic                     out_free;

   usph_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (ctrl.take),
      .item_vld   (item_vld),
      .item       (item)
   );

   usph_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item     (item),
      .out_free (out_free),
      .ctrl     (ctrl),
      .result   (result)
   );

   usph_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/core/usph_in_reg.sv
// input word register of the url splitter
module usph_in_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [usph_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   input  logic                            take,
   output logic                            item_vld,
   output usph_pkg::item_type              item
);

   logic               vld_ff, vld_in;
   usph_pkg::item_type item_ff;

   assign req_tready = !vld_ff || take;

   always_comb begin
      vld_in = vld_ff;
      if (req_tvalid && req_tready) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.data <= req_tdata[usph_pkg::BYTE_W-1:0];
         item_ff.last <= req_tlast;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

>>> rtl/core/usph_parse.sv
// per-url parse state and next-state logic of the url splitter
module usph_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_vld,
   input  usph_pkg::item_type       item,
   input  logic                     out_free,
   output usph_pkg::parse_ctrl_type ctrl,
   output usph_pkg::result_type     result
);

   usph_pkg::phase_type           phase_ff, phase_in;
   logic [usph_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [usph_pkg::POS_W-1:0]    scheme_ff, scheme_in;
   logic [usph_pkg::POS_W-1:0]    hstart_ff, hstart_in;
   logic [usph_pkg::POS_W-1:0]    hend_ff, hend_in;
   logic [usph_pkg::PORT_W-1:0]   acc_ff, acc_in;
   logic [usph_pkg::PORT_W-1:0]   digit;
   logic                          emit;
   usph_pkg::status_type          status;
   logic                          take;

   assign digit = usph_pkg::PORT_W'(item.data - usph_pkg::CH_0);

   always_comb begin
      phase_in  = phase_ff;
      scheme_in = scheme_ff;
      hstart_in = hstart_ff;
      hend_in   = hend_ff;
      acc_in    = acc_ff;
      emit      = 1'b0;
      status    = usph_pkg::ST_OK;

      case (phase_ff)
         usph_pkg::PH_SCHEME: begin
            if (item.data == usph_pkg::CH_COLON) begin
               scheme_in = pos_ff;
               phase_in  = usph_pkg::PH_SLASH1;
            end
         end
         usph_pkg::PH_SLASH1: begin
            if (item.data == usph_pkg::CH_SLASH) begin
               phase_in = usph_pkg::PH_SLASH2;
            end else begin
               emit   = 1'b1;
               status = usph_pkg::ST_NOSLASH;
            end
         end
         usph_pkg::PH_SLASH2: begin
            if (item.data == usph_pkg::CH_SLASH) begin
               hstart_in = usph_pkg::sat_next(pos_ff);
               phase_in  = usph_pkg::PH_HOST;
            end else begin
               emit   = 1'b1;
               status = usph_pkg::ST_NOSLASH;
            end
         end
         usph_pkg::PH_HOST: begin
            if (item.data == usph_pkg::CH_COLON) begin
               hend_in  = pos_ff;
               phase_in = usph_pkg::PH_PORT;
            end
         end
         usph_pkg::PH_PORT: begin
            if (item.data inside {[usph_pkg::CH_0:usph_pkg::CH_9]}) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
            end else if (item.data == usph_pkg::CH_NUL) begin
               emit   = 1'b1;
               status = usph_pkg::ST_OK;
            end else begin
               emit   = 1'b1;
               status = usph_pkg::ST_BADPORT;
            end
         end
         default: begin
         end
      endcase

      // end of url decides whatever is still open
      if (!emit && item.last) begin
         case (phase_in)
            usph_pkg::PH_SLASH1, usph_pkg::PH_SLASH2: begin
               emit   = 1'b1;
               status = usph_pkg::ST_NOSLASH;
            end
            usph_pkg::PH_PORT: begin
               emit   = 1'b1;
               status = usph_pkg::ST_OK;
            end
            usph_pkg::PH_SCHEME, usph_pkg::PH_HOST: begin
               emit   = 1'b1;
               status = usph_pkg::ST_NOPORT;
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         phase_in = usph_pkg::PH_DONE;
      end
   end

   assign pos_in = usph_pkg::sat_next(pos_ff);
   assign take   = item_vld && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= usph_pkg::PH_SCHEME;
         pos_ff    <= '0;
         scheme_ff <= '0;
         hstart_ff <= '0;
         hend_ff   <= '0;
         acc_ff    <= '0;
      end else if (take) begin
         if (item.last) begin
            phase_ff  <= usph_pkg::PH_SCHEME;
            pos_ff    <= '0;
            scheme_ff <= '0;
            hstart_ff <= '0;
            hend_ff   <= '0;
            acc_ff    <= '0;
         end else begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            scheme_ff <= scheme_in;
            hstart_ff <= hstart_in;
            hend_ff   <= hend_in;
            acc_ff    <= acc_in;
         end
      end
   end

   assign ctrl.take = take;
   assign ctrl.emit = emit;

   assign result.status      = status;
   assign result.scheme_len  = usph_pkg::to_idx(scheme_in);
   assign result.host_start  = usph_pkg::to_idx(hstart_in);
   assign result.host_end    = usph_pkg::to_idx(hend_in);
   assign result.port_number = (status == usph_pkg::ST_OK) ? acc_in : '0;

endmodule

>>> rtl/core/usph_out_reg.sv
// result word register of the url splitter
module usph_out_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  usph_pkg::parse_ctrl_type        ctrl,
   input  usph_pkg::result_type            result,
   output logic                            out_free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [usph_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [usph_pkg::STATUS_W-1:0]   rsp_tuser
);

   logic                 vld_ff, vld_in;
   logic                 load;
   usph_pkg::result_type res_ff;

   assign out_free = !vld_ff || rsp_tready;
   assign load     = ctrl.take && ctrl.emit;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {2'b00, res_ff.port_number, res_ff.host_end,
                        res_ff.host_start, res_ff.scheme_len};

endmodule

>>> rtl/core/usph_checker.sv
// port-level checks of the url splitter, bound to the top level
`include "url_scheme_host_port_splitter_defines.svh"

module usph_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [usph_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [usph_pkg::STATUS_W-1:0]   rsp_tuser
);

   logic ok_word;
   logic idx_order;
   logic port_zero;

   assign ok_word   = rsp_tvalid && (rsp_tuser == usph_pkg::ST_OK);
   assign idx_order = (rsp_tdata[29:20] >= rsp_tdata[19:10]) &&
                      (rsp_tdata[19:10] >= rsp_tdata[9:0]);
   assign port_zero = (rsp_tdata[45:30] == '0);

   `USPH_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid)
   `USPH_ASSERT_NOW(a_port_only_when_ok, clock, reset,
                    rsp_tvalid && (rsp_tuser != usph_pkg::ST_OK), port_zero)
   `USPH_ASSERT_NOW(a_ok_index_order, clock, reset, ok_word, idx_order)
   `USPH_ASSERT_NEXT(a_rsp_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind url_scheme_host_port_splitter usph_checker u_checker (.*);

>>> sim/url_parse_check.sv
// checker for the url splitter: predicts each url's result word and compares it
module url_parse_check
   import usph_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // byte_in
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scheme_len, host_start, host_end, port_number, zero fill
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,  // status
   output int unsigned           mismatch_count,
   output int unsigned           outstanding,
   output int unsigned           results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_LSB = 3 * IDX_W + PORT_W;

   phase_type         url_phase = PH_SCHEME;
   logic [POS_W-1:0]  url_pos = '0;
   logic [POS_W-1:0]  colon_pos = '0;
   logic [POS_W-1:0]  host_first = '0;
   logic [POS_W-1:0]  host_last = '0;
   logic [PORT_W-1:0] port_value = '0;
   result_type        expected_results[$];
   result_type        got;
   result_type        want;
   int unsigned       misses = 0;
   int unsigned       checked = 0;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      return p + POS_W'(p != POS_W'(MAX_LEN - 1));
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("status %0d scheme_len %0d host_start %0d host_end %0d port %0d",
                       r.status, r.scheme_len, r.host_start, r.host_end, r.port_number);
   endfunction

   function automatic void start_url();
      url_phase  = PH_SCHEME;
      url_pos    = '0;
      colon_pos  = '0;
      host_first = '0;
      host_last  = '0;
      port_value = '0;
   endfunction

   function automatic void decide(input status_type s);
      result_type r;
      r.status      = s;
      r.scheme_len  = IDX_W'(colon_pos);
      r.host_start  = IDX_W'(host_first);
      r.host_end    = IDX_W'(host_last);
      r.port_number = (s == ST_OK) ? port_value : '0;
      expected_results.push_back(r);
      url_phase = PH_DONE;
   endfunction

   function automatic void parse_char(input logic [BYTE_W-1:0] c, input logic fin);
      logic decided;
      decided = 1'b0;
      case (url_phase)
         PH_SCHEME: begin
            if (c == CH_COLON) begin
               colon_pos = url_pos;
               url_phase = PH_SLASH1;
            end
         end
         PH_SLASH1: begin
            if (c == CH_SLASH) begin
               url_phase = PH_SLASH2;
            end else begin
               decide(ST_NOSLASH);
               decided = 1'b1;
            end
         end
         PH_SLASH2: begin
            if (c == CH_SLASH) begin
               host_first = next_pos(url_pos);
               url_phase  = PH_HOST;
            end else begin
               decide(ST_NOSLASH);
               decided = 1'b1;
            end
         end
         PH_HOST: begin
            if (c == CH_COLON) begin
               host_last = url_pos;
               url_phase = PH_PORT;
            end
         end
         PH_PORT: begin
            if (c >= CH_0 && c <= CH_9) begin
               port_value = port_value * PORT_W'(10) + PORT_W'(c - CH_0);
            end else if (c == CH_NUL) begin
               decide(ST_OK);
               decided = 1'b1;
            end else begin
               decide(ST_BADPORT);
               decided = 1'b1;
            end
         end
         default: ;
      endcase
      url_pos = next_pos(url_pos);
      if (fin) begin
         if (!decided) begin
            case (url_phase)
               PH_SLASH1, PH_SLASH2: decide(ST_NOSLASH);
               PH_PORT:              decide(ST_OK);
               PH_SCHEME, PH_HOST:   decide(ST_NOPORT);
               default: ;
            endcase
         end
         start_url();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start_url();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            got.status      = status_type'(rsp_tuser);
            got.scheme_len  = rsp_tdata[IDX_W-1:0];
            got.host_start  = rsp_tdata[2*IDX_W-1:IDX_W];
            got.host_end    = rsp_tdata[3*IDX_W-1:2*IDX_W];
            got.port_number = rsp_tdata[FILL_LSB-1:3*IDX_W];
            if (expected_results.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("%0t: result word with nothing expected: %s",
                           $realtime, describe(got));
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status || got.scheme_len != want.scheme_len ||
                   got.host_start != want.host_start || got.host_end != want.host_end ||
                   got.port_number != want.port_number ||
                   rsp_tdata[RSP_DATA_W-1:FILL_LSB] != '0) begin
                  misses++;
                  if (misses <= 10)
                     $display("%0t: result %0d mismatch\n  expected %s\n  actual   %s fill %0h",
                              $realtime, checked, describe(want), describe(got),
                              rsp_tdata[RSP_DATA_W-1:FILL_LSB]);
               end
            end
         end
         if (req_tvalid && req_tready)
            parse_char(req_tdata, req_tlast);
      end
      mismatch_count  <= misses;
      outstanding     <= expected_results.size();
      results_checked <= checked;
   end

endmodule

>>> sim/testbench.sv
// testbench top for the url splitter: reset, url stimulus, receiver stalls and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 640;
   localparam int HOLD_CYCLES  = 300;
   localparam int LONG_SCHEME  = 1030;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [usph_pkg::REQ_DATA_W-1:0] req_tdata;  // byte_in
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // scheme_len, host_start, host_end, port_number, zero fill
   logic [usph_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [usph_pkg::STATUS_W-1:0]   rsp_tuser;  // status

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned results_checked;

   logic [usph_pkg::BYTE_W-1:0] url_bytes[$];
   int unsigned                 urls_sent = 0;
   int unsigned                 bytes_sent = 0;
   logic                        quiet = 1'b0;
   logic                        hold_off = 1'b0;

   always #5 clock = ~clock;

   url_scheme_host_port_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   url_parse_check parse_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   task automatic send_word(input logic [usph_pkg::BYTE_W-1:0] b, input logic fin);
      while (!quiet && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_url();
      for (int i = 0; i < url_bytes.size(); i++)
         send_word(url_bytes[i], i == url_bytes.size() - 1);
      url_bytes.delete();
      urls_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         url_bytes.push_back(s[i]);
   endtask

   function automatic logic [usph_pkg::BYTE_W-1:0] any_byte();
      return usph_pkg::BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [usph_pkg::BYTE_W-1:0] any_but_colon();
      logic [usph_pkg::BYTE_W-1:0] c;
      do c = any_byte(); while (c == usph_pkg::CH_COLON);
      return c;
   endfunction

   function automatic logic [usph_pkg::BYTE_W-1:0] non_digit();
      logic [usph_pkg::BYTE_W-1:0] c;
      do c = any_byte();
      while (c == usph_pkg::CH_NUL || (c >= usph_pkg::CH_0 && c <= usph_pkg::CH_9));
      return c;
   endfunction

   // mostly well-formed urls with random content, some broken ones and some noise
   task automatic build_random_url();
      int unsigned kind;
      int unsigned n;
      int unsigned cut;
      kind = $urandom_range(99);
      if (kind < 15) begin
         n = $urandom_range(1, 12);
         repeat (n) url_bytes.push_back(any_byte());
      end else begin
         n = $urandom_range(0, 6);
         repeat (n) url_bytes.push_back(any_but_colon());
         push_text("://");
         n = $urandom_range(0, 8);
         repeat (n) url_bytes.push_back(any_but_colon());
         url_bytes.push_back(usph_pkg::CH_COLON);
         n = $urandom_range(0, 7);
         repeat (n)
            url_bytes.push_back(usph_pkg::CH_0 + usph_pkg::BYTE_W'($urandom_range(9)));
         case ($urandom_range(2))
            1: url_bytes.push_back(usph_pkg::CH_NUL);
            2: url_bytes.push_back(non_digit());
            default: ;
         endcase
         n = $urandom_range(0, 3);
         repeat (n) url_bytes.push_back(any_byte());
         if (kind < 30) begin
            if ($urandom_range(1)) begin
               cut = $urandom_range(1, url_bytes.size());
               while (url_bytes.size() > cut) void'(url_bytes.pop_back());
            end else begin
               url_bytes[$urandom_range(url_bytes.size() - 1)] = any_byte();
            end
         end
      end
   endtask

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 15);
            @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still expected", outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_urls;
      int unsigned random_start;
      int unsigned waited;
      random_urls = 0;
      waited = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end after the colon, after one slash, and slashes missing
      push_text(":");
      send_url();
      push_text(":/");
      send_url();
      push_text(":x");
      send_url();
      push_text(":/x");
      send_url();
      // end in the host and in the scheme
      push_text("://");
      send_url();
      push_text("x");
      send_url();
      // nul ends the port, then trailing bytes are ignored
      push_text("://:9");
      url_bytes.push_back(usph_pkg::CH_NUL);
      push_text("z");
      send_url();
      // bad port character at the top byte value
      push_text("://:");
      url_bytes.push_back(8'hff);
      send_url();
      // empty port ended by the last flag
      push_text("://:");
      send_url();

      // positions saturate in a long url
      repeat (LONG_SCHEME) url_bytes.push_back(8'h61);
      push_text("://h:80");
      send_url();

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_ITEMS) begin
         quiet = (random_urls >= 3 && random_urls < 13);
         if (random_urls == 15)
            hold_off = 1'b1;
         build_random_url();
         send_url();
         random_urls++;
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      $display("ran %0d urls in %0d bytes, %0d result words checked", urls_sent, bytes_sent,
               results_checked);
      $display("included a %0d-byte url and a %0d-cycle receiver hold-off; %0d results missing",
               LONG_SCHEME + 7, HOLD_CYCLES, outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
